FILE: rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types for the limit order book matcher: item, result, book entry,
// controller states and the command/status groups between the two halves.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int PRICE_W = 16;
  localparam int QTY_W   = 16;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic               command;
    logic               is_sell;
    logic [QTY_W-1:0]   order_quantity;
    logic [PRICE_W-1:0] order_price;
  } order_t;

  typedef struct packed {
    logic [PRICE_W-1:0] best_ask;
    logic               best_ask_valid;
    logic [PRICE_W-1:0] best_bid;
    logic               best_bid_valid;
    logic [PRICE_W-1:0] last_price;
    logic               last_price_valid;
    logic               book_overflow;
  } result_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN_M,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_SCAN_R,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_book;
    logic scan_init;
    logic scan_step;
    logic trade;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic remove_done;
    logic insert;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic qty_zero;
    logic other_empty;
    logic crosses;
    logic fill_all;
    logic shift_more;
  } dp_status_t;

endpackage

FILE: rtl/limit_order_book_matcher_core.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Two-sided limit order book with continuous matching, one report per item.
// ----------------------------------------------------------------------------
// Accept to done: a clear runs the final scan and reports; a submit scans the
//   larger side count per match attempt, shifts the entries behind a filled
//   entry to close its gap, inserts any rest, then scans again and reports.
// Throughput: one item at a time; busy stays high until the report is issued.
// Reset: empties both sides and forgets the last price; no memory clearing.
// Results are strobed by done for one cycle and cannot be stalled.
module limit_order_book_matcher_core import lobm_pkg::*; #(
  parameter int BOOK_DEPTH = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  order_t  order,
  output logic    done,
  output result_t report
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lobm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (order.command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  lobm_datapath #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .order  (order),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (report)
  );

endmodule

FILE: rtl/lobm_ctrl.sv
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer: match loop (scan, trade, remove), insert, final scan, report.
// ----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       command,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (command == CMD_CLEAR) begin
            cmd.clear_book = 1'b1;
            cmd.scan_init  = 1'b1;
            state_next     = ST_SCAN_R;
          end else begin
            state_next = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        if (status.qty_zero || status.other_empty) begin
          state_next = ST_INSERT;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN_M;
        end
      end
      ST_SCAN_M: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.crosses) begin
          state_next = ST_INSERT;
        end else begin
          cmd.trade = 1'b1;
          if (status.fill_all) begin
            cmd.shift_init = 1'b1;
            state_next     = ST_SHIFT_RD;
          end else begin
            state_next = ST_MATCH;
          end
        end
      end
      ST_SHIFT_RD: begin
        if (status.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = ST_SHIFT_WR;
        end else begin
          cmd.remove_done = 1'b1;
          state_next      = ST_MATCH;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ST_SHIFT_RD;
      end
      ST_INSERT: begin
        cmd.insert    = 1'b1;
        cmd.scan_init = 1'b1;
        state_next    = ST_SCAN_R;
      end
      ST_SCAN_R: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lobm_datapath.sv
// ----------------------------------------------------------------------------
// lobm_datapath
// Book memories for both sides, counts, scan trackers, trade arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module lobm_datapath import lobm_pkg::*; #(
  parameter int BOOK_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  order_t     order,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       done,
  output result_t    result
);

  localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

  entry_t ask_mem [BOOK_DEPTH];
  entry_t bid_mem [BOOK_DEPTH];
  entry_t ask_rd, bid_rd;

  logic               sell;
  logic [QTY_W-1:0]   qty;
  logic [PRICE_W-1:0] price;
  logic [CW-1:0]      ask_count, bid_count;
  logic [PRICE_W-1:0] last_trade;
  logic               trade_seen;
  logic               overflow;

  logic [CW-1:0]      k, kd;
  logic               rvalid;
  entry_t             ask_best, bid_best;
  logic [CW-1:0]      ask_idx, bid_idx;
  logic [CW-1:0]      j;

  logic [CW-1:0]      limit, other_count, own_count, j_inc, best_idx;
  entry_t             other_best, other_rd;
  logic [QTY_W-1:0]   fill;
  logic [AW-1:0]      ra;
  logic               ask_we, bid_we;
  logic [AW-1:0]      ask_wa, bid_wa;
  entry_t             ask_wd, bid_wd;
  logic               o_we, w_own;
  logic [AW-1:0]      o_wa;
  entry_t             o_wd;

  assign limit       = (ask_count > bid_count) ? ask_count : bid_count;
  assign other_count = sell ? bid_count : ask_count;
  assign own_count   = sell ? ask_count : bid_count;
  assign other_best  = sell ? bid_best : ask_best;
  assign other_rd    = sell ? bid_rd : ask_rd;
  assign best_idx    = sell ? bid_idx : ask_idx;
  assign j_inc       = j + CW'(1);
  assign fill        = (qty < other_best.qty) ? qty : other_best.qty;

  assign status.scan_done   = (k >= limit) && !rvalid;
  assign status.qty_zero    = (qty == '0);
  assign status.other_empty = (other_count == '0);
  assign status.crosses     = sell ? !(other_best.price < price) : !(price < other_best.price);
  assign status.fill_all    = (other_best.qty <= qty);
  assign status.shift_more  = (j_inc < other_count);

  assign ra = cmd.shift_rd ? j_inc[AW-1:0] : k[AW-1:0];

  always_comb begin
    o_we  = 1'b0;
    o_wa  = best_idx[AW-1:0];
    o_wd  = '{price: other_best.price, qty: other_best.qty - fill};
    w_own = cmd.insert && (qty != '0) && (own_count < DEPTH_C);
    if (cmd.trade && !status.fill_all) begin
      o_we = 1'b1;
    end else if (cmd.shift_wr) begin
      o_we = 1'b1;
      o_wa = j[AW-1:0];
      o_wd = other_rd;
    end
    ask_we = 1'b0;
    bid_we = 1'b0;
    ask_wa = o_wa;
    bid_wa = o_wa;
    ask_wd = o_wd;
    bid_wd = o_wd;
    if (w_own) begin
      if (sell) begin
        ask_we = 1'b1;
        ask_wa = own_count[AW-1:0];
        ask_wd = '{price: price, qty: qty};
      end else begin
        bid_we = 1'b1;
        bid_wa = own_count[AW-1:0];
        bid_wd = '{price: price, qty: qty};
      end
    end else if (o_we) begin
      if (sell) bid_we = 1'b1;
      else      ask_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ask_we) ask_mem[ask_wa] <= ask_wd;
    ask_rd <= ask_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (bid_we) bid_mem[bid_wa] <= bid_wd;
    bid_rd <= bid_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sell  <= order.is_sell;
      qty   <= order.order_quantity;
      price <= order.order_price;
    end else if (cmd.trade) begin
      qty <= qty - fill;
    end
    if (cmd.scan_step && (k < limit)) kd <= k;
    if (rvalid) begin
      if ((kd < ask_count) && ((kd == '0) || (ask_rd.price < ask_best.price))) begin
        ask_best <= ask_rd;
        ask_idx  <= kd;
      end
      if ((kd < bid_count) && ((kd == '0) || (bid_rd.price > bid_best.price))) begin
        bid_best <= bid_rd;
        bid_idx  <= kd;
      end
    end
    if (cmd.shift_init) j <= best_idx;
    else if (cmd.shift_wr) j <= j_inc;
    if (cmd.emit) begin
      result.best_ask         <= (ask_count != '0) ? ask_best.price : '0;
      result.best_ask_valid   <= (ask_count != '0);
      result.best_bid         <= (bid_count != '0) ? bid_best.price : '0;
      result.best_bid_valid   <= (bid_count != '0);
      result.last_price       <= trade_seen ? last_trade : '0;
      result.last_price_valid <= trade_seen;
      result.book_overflow    <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ask_count  <= '0;
      bid_count  <= '0;
      last_trade <= '0;
      trade_seen <= 1'b0;
      overflow   <= 1'b0;
      k          <= '0;
      rvalid     <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.load) overflow <= 1'b0;
      if (cmd.clear_book) begin
        ask_count  <= '0;
        bid_count  <= '0;
        last_trade <= '0;
        trade_seen <= 1'b0;
      end
      if (cmd.trade) begin
        last_trade <= sell ? price : other_best.price;
        trade_seen <= 1'b1;
      end
      if (cmd.remove_done) begin
        if (sell) bid_count <= bid_count - CW'(1);
        else      ask_count <= ask_count - CW'(1);
      end
      if (cmd.insert && (qty != '0)) begin
        if (own_count < DEPTH_C) begin
          if (sell) ask_count <= ask_count + CW'(1);
          else      bid_count <= bid_count + CW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.scan_init) begin
        k      <= '0;
        rvalid <= 1'b0;
      end else if (cmd.scan_step) begin
        if (k < limit) begin
          k      <= k + CW'(1);
          rvalid <= 1'b1;
        end else begin
          rvalid <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (ask_count <= DEPTH_C) && (bid_count <= DEPTH_C))
    else $error("book count beyond depth");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_book |=> (ask_count == '0) && (bid_count == '0) && !trade_seen)
    else $error("clear left entries");
  a_trade_seen: assert property (@(posedge clk) disable iff (rst)
    cmd.trade |=> trade_seen && ($past(qty) >= qty))
    else $error("trade bookkeeping wrong");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

FILE: sim/limit_order_book_matcher_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core_test
// Drives orders and clears into the matcher and checks every report against a
// behavioural book kept in the bench: price/time priority, partial fills,
// full-side drops and clears, with random gaps between most items.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core_test;
  import lobm_pkg::*;

  localparam int DEPTH = 256;
  localparam int WATCHDOG = 1000000;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  order_t  order;
  logic    done;
  result_t report;

  limit_order_book_matcher_core #(.BOOK_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .order(order), .done(done), .report(report)
  );

  entry_t    asks[$];
  entry_t    bids[$];
  logic [PRICE_W-1:0] last_px;
  logic      traded;
  result_t   pending_reports[$];
  int        errors;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int best_of(ref entry_t side[$], input bit lowest);
    int b;
    b = 0;
    for (int i = 1; i < side.size(); i++)
      if (lowest ? side[i].price < side[b].price : side[i].price > side[b].price)
        b = i;
    return b;
  endfunction

  task automatic book_apply(input order_t o);
    result_t r;
    int idx;
    logic [QTY_W-1:0] q, fill;
    r = '0;
    if (o.command == CMD_CLEAR) begin
      asks.delete();
      bids.delete();
      last_px = '0;
      traded = 1'b0;
    end else begin
      q = o.order_quantity;
      if (o.is_sell) begin
        while (q != 0 && bids.size() > 0) begin
          idx = best_of(bids, 1'b0);
          if (bids[idx].price < o.order_price) break;
          last_px = o.order_price;
          traded = 1'b1;
          fill = q < bids[idx].qty ? q : bids[idx].qty;
          q -= fill;
          bids[idx].qty -= fill;
          if (bids[idx].qty == 0) bids.delete(idx);
        end
        if (q != 0) begin
          if (asks.size() < DEPTH) asks.push_back('{o.order_price, q});
          else r.book_overflow = 1'b1;
        end
      end else begin
        while (q != 0 && asks.size() > 0) begin
          idx = best_of(asks, 1'b1);
          if (o.order_price < asks[idx].price) break;
          last_px = asks[idx].price;
          traded = 1'b1;
          fill = q < asks[idx].qty ? q : asks[idx].qty;
          q -= fill;
          asks[idx].qty -= fill;
          if (asks[idx].qty == 0) asks.delete(idx);
        end
        if (q != 0) begin
          if (bids.size() < DEPTH) bids.push_back('{o.order_price, q});
          else r.book_overflow = 1'b1;
        end
      end
    end
    if (asks.size() > 0) begin
      r.best_ask = asks[best_of(asks, 1'b1)].price;
      r.best_ask_valid = 1'b1;
    end
    if (bids.size() > 0) begin
      r.best_bid = bids[best_of(bids, 1'b0)].price;
      r.best_bid_valid = 1'b1;
    end
    r.last_price = traded ? last_px : '0;
    r.last_price_valid = traded;
    pending_reports.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  // entered at a falling edge; busy only moves at rising edges
  task automatic send_item(input order_t o, input bit gaps = 1'b1);
    while (busy) @(negedge clk);
    order <= o;
    start <= 1'b1;
    @(negedge clk);
    start <= 1'b0;
    book_apply(o);
    if (gaps) random_gap();
  endtask

  function automatic order_t mk(input logic cmd, input logic sell,
                                input int q, input int p);
    order_t o;
    o.command = cmd;
    o.is_sell = sell;
    o.order_quantity = q[QTY_W-1:0];
    o.order_price = p[PRICE_W-1:0];
    return o;
  endfunction

  task automatic wait_drained();
    while (pending_reports.size() > 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
      if (done) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("unexpected report", 1, 0);
        end else begin
          e = pending_reports.pop_front();
          if (report.best_ask !== e.best_ask)
            report_mismatch("best_ask", report.best_ask, e.best_ask);
          if (report.best_ask_valid !== e.best_ask_valid)
            report_mismatch("best_ask_valid", report.best_ask_valid, e.best_ask_valid);
          if (report.best_bid !== e.best_bid)
            report_mismatch("best_bid", report.best_bid, e.best_bid);
          if (report.best_bid_valid !== e.best_bid_valid)
            report_mismatch("best_bid_valid", report.best_bid_valid, e.best_bid_valid);
          if (report.last_price !== e.last_price)
            report_mismatch("last_price", report.last_price, e.last_price);
          if (report.last_price_valid !== e.last_price_valid)
            report_mismatch("last_price_valid", report.last_price_valid,
                            e.last_price_valid);
          if (report.book_overflow !== e.book_overflow)
            report_mismatch("book_overflow", report.book_overflow, e.book_overflow);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(mk(CMD_SUBMIT, 1'b0, 0, 100));
    send_item(mk(CMD_SUBMIT, 1'b1, 10, 200));
    send_item(mk(CMD_SUBMIT, 1'b1, 5, 200));
    send_item(mk(CMD_SUBMIT, 1'b0, 12, 199));
    send_item(mk(CMD_SUBMIT, 1'b0, 12, 250));
    send_item(mk(CMD_SUBMIT, 1'b1, 1, 65535));
    send_item(mk(CMD_SUBMIT, 1'b0, 65535, 0));
    send_item(mk(CMD_SUBMIT, 1'b1, 65535, 0));
    send_item(mk(CMD_SUBMIT, 1'b0, 65535, 65535));
    send_item(mk(CMD_SUBMIT, 1'b0, 3, 300));
    send_item(mk(CMD_SUBMIT, 1'b0, 4, 300));
    send_item(mk(CMD_SUBMIT, 1'b1, 5, 300));
    send_item(mk(CMD_SUBMIT, 1'b1, 0, 1));
    send_item(mk(CMD_CLEAR, 1'b1, 65535, 65535));
    send_item(mk(CMD_SUBMIT, 1'b1, 7, 42));
    send_item(mk(CMD_CLEAR, 1'b0, 0, 0));
  endtask

  // fill both sides beyond depth, then cross part of the ask side
  task automatic test_full_side();
    for (int i = 0; i < DEPTH + 3; i++)
      send_item(mk(CMD_SUBMIT, 1'b1, $urandom_range(1, 3), $urandom_range(1000, 1100)),
                1'b0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(mk(CMD_SUBMIT, 1'b0, 1, $urandom_range(0, 999)), 1'b0);
    send_item(mk(CMD_SUBMIT, 1'b0, 20, 1050));
    wait_drained();
    send_item(mk(CMD_CLEAR, 1'b0, 0, 0));
  endtask

  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k == 0)
        send_item(mk(CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom));
      else if (k < 5)
        send_item(mk(CMD_SUBMIT, 1'($urandom_range(0, 1)), $urandom, $urandom));
      else
        send_item(mk(CMD_SUBMIT, 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1, 50),
                     $urandom_range(990, 1010)));
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    order = '0;
    last_px = '0;
    traded = 1'b0;
    errors = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_side();
    test_random(170);
    wait_drained();
    repeat (600) @(negedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
